@@ rtl/core/hsdf_pkg.sv @@
// ----------------------------------------------------------------------------
// hsdf_pkg: shared types and constants of the half-space direction filter
// Register indexes, configuration record, inter-stage payload and helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package hsdf_pkg;

    localparam int IDX_W    = 20;
    localparam int WORD_W   = 32;
    localparam int NRM_W    = 16;
    localparam int CFG_IX_W = 2;
    localparam int FRAC_SH  = 14;
    localparam int DIFF_W   = 39;

    typedef enum logic [CFG_IX_W-1:0] {
        CFG_NORMAL_X     = 2'd0,
        CFG_NORMAL_Y     = 2'd1,
        CFG_NORMAL_Z     = 2'd2,
        CFG_PLANE_OFFSET = 2'd3
    } t_cfg_index;

    localparam logic signed [NRM_W-1:0] NORMAL_X_RST = 16'sd0;
    localparam logic signed [NRM_W-1:0] NORMAL_Y_RST = 16'sd16384;
    localparam logic signed [NRM_W-1:0] NORMAL_Z_RST = 16'sd0;
    localparam logic signed [WORD_W-1:0] OFFSET_RST  = 32'sd0;

    typedef struct packed {
        logic signed [NRM_W-1:0]  normal_x;
        logic signed [NRM_W-1:0]  normal_y;
        logic signed [NRM_W-1:0]  normal_z;
        logic signed [WORD_W-1:0] plane_offset;
    } t_cfg;

    typedef struct packed {
        logic [IDX_W-1:0]         index;
        logic signed [WORD_W-1:0] dir_x;
        logic signed [WORD_W-1:0] dir_y;
        logic signed [WORD_W-1:0] dir_z;
        logic signed [DIFF_W-1:0] diff;
        logic                     active;
        logic signed [WORD_W-1:0] gap;
    } t_mid;

    // Divide by 2^14, rounding to nearest with ties toward plus infinity.
    function automatic logic signed [63:0] round_q14(input logic signed [63:0] x);
        logic signed [63:0] y;
        y = x + (64'sd1 <<< (FRAC_SH - 1));
        return y >>> FRAC_SH;
    endfunction

    function automatic logic signed [WORD_W-1:0] sat32(input logic signed [63:0] x);
        logic signed [WORD_W-1:0] r;
        if (x > 64'sd2147483647) begin
            r = 32'sh7fff_ffff;
        end else if (x < -64'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = x[WORD_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/hsdf_vertex_if.sv @@
// ----------------------------------------------------------------------------
// hsdf_vertex_if: vertex request channel
// Valid/ready channel carrying one vertex index, position and direction.
// ----------------------------------------------------------------------------
`default_nettype none

interface hsdf_vertex_if;
    logic                valid;
    logic                ready;
    logic [19:0]         vertex_index;
    logic signed [31:0]  pos_x;
    logic signed [31:0]  pos_y;
    logic signed [31:0]  pos_z;
    logic signed [31:0]  dir_x;
    logic signed [31:0]  dir_y;
    logic signed [31:0]  dir_z;

    modport source (output valid, vertex_index, pos_x, pos_y, pos_z,
                    dir_x, dir_y, dir_z, input ready);
    modport sink   (input valid, vertex_index, pos_x, pos_y, pos_z,
                    dir_x, dir_y, dir_z, output ready);
endinterface

`default_nettype wire

@@ rtl/core/hsdf_result_if.sv @@
// ----------------------------------------------------------------------------
// hsdf_result_if: filter result channel
// Valid/ready channel carrying the filtered direction, flag and gap.
// ----------------------------------------------------------------------------
`default_nettype none

interface hsdf_result_if;
    logic                valid;
    logic                ready;
    logic [19:0]         out_index;
    logic signed [31:0]  new_dir_x;
    logic signed [31:0]  new_dir_y;
    logic signed [31:0]  new_dir_z;
    logic                active;
    logic signed [31:0]  signed_gap;

    modport source (output valid, out_index, new_dir_x, new_dir_y, new_dir_z,
                    active, signed_gap, input ready);
    modport sink   (input valid, out_index, new_dir_x, new_dir_y, new_dir_z,
                    active, signed_gap, output ready);
endinterface

`default_nettype wire

@@ rtl/core/halfspace_search_dir_filter_unit.sv @@
// ----------------------------------------------------------------------------
// halfspace_search_dir_filter_unit: half-space search direction filter
// Tests each vertex against a configured plane and trims its direction.
// ----------------------------------------------------------------------------
// Vertex requests enter on i_vtx and results leave on o_res, both valid/ready
// channels; a request moves when valid and ready are high at a clock edge.
// The user must write the plane normal and offset through i_cfg_we, i_cfg_idx
// and i_cfg_data only with no request in flight; the block does not check it.
// Each request passes five register stages: normal products, gap and rate
// sums, activity test with rounded difference, correction products, and the
// rounded subtraction into the output register. One request is accepted every
// cycle while the receiver takes results. Every stage has its own valid bit
// and loads whenever it is empty or its successor moves, so a stalled receiver
// fills the pipeline bubble by bubble and then holds i_vtx.ready low without
// losing a request.
// A synchronous reset empties the pipeline and restores the default plane,
// normal (0, 1, 0) and offset zero. With DIMENSION 2 the z inputs and the z
// normal are ignored and new_dir_z is zero.
// ----------------------------------------------------------------------------
`default_nettype none

module halfspace_search_dir_filter_unit #(
    parameter int DIMENSION = 3
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [hsdf_pkg::CFG_IX_W-1:0]      i_cfg_idx,
    input  wire logic [hsdf_pkg::WORD_W-1:0]        i_cfg_data,
    hsdf_vertex_if.sink                             i_vtx,
    hsdf_result_if.source                           o_res
);

    localparam bit ThreeD = (DIMENSION >= 3);

    hsdf_pkg::t_cfg r_cfg;
    hsdf_pkg::t_cfg n_cfg;
    hsdf_pkg::t_cfg cfg_eff;
    hsdf_pkg::t_mid mid;
    logic           mid_valid;
    logic           mid_ready;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (hsdf_pkg::t_cfg_index'(i_cfg_idx))
                hsdf_pkg::CFG_NORMAL_X:     n_cfg.normal_x = i_cfg_data[hsdf_pkg::NRM_W-1:0];
                hsdf_pkg::CFG_NORMAL_Y:     n_cfg.normal_y = i_cfg_data[hsdf_pkg::NRM_W-1:0];
                hsdf_pkg::CFG_NORMAL_Z:     n_cfg.normal_z = i_cfg_data[hsdf_pkg::NRM_W-1:0];
                hsdf_pkg::CFG_PLANE_OFFSET: n_cfg.plane_offset = i_cfg_data;
                default:                    n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.normal_x     <= hsdf_pkg::NORMAL_X_RST;
            r_cfg.normal_y     <= hsdf_pkg::NORMAL_Y_RST;
            r_cfg.normal_z     <= hsdf_pkg::NORMAL_Z_RST;
            r_cfg.plane_offset <= hsdf_pkg::OFFSET_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        cfg_eff = r_cfg;
        if (!ThreeD) begin
            cfg_eff.normal_z = '0;
        end
    end

    hsdf_gap_rate #(
        .DIMENSION (DIMENSION)
    ) u_gap_rate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_eff),
        .i_vtx   (i_vtx),
        .o_valid (mid_valid),
        .i_ready (mid_ready),
        .o_mid   (mid)
    );

    hsdf_dir_update u_dir_update (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_eff),
        .i_valid (mid_valid),
        .o_ready (mid_ready),
        .i_mid   (mid),
        .o_res   (o_res)
    );

endmodule

`default_nettype wire

@@ rtl/core/hsdf_gap_rate.sv @@
// ----------------------------------------------------------------------------
// hsdf_gap_rate: dot products, gap, rate and activity test
// Three stages: normal products, gap and rate sums, test and rounded diff.
// ----------------------------------------------------------------------------
`default_nettype none

module hsdf_gap_rate #(
    parameter int DIMENSION = 3
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire hsdf_pkg::t_cfg i_cfg,
    hsdf_vertex_if.sink        i_vtx,
    output logic               o_valid,
    input  wire logic          i_ready,
    output hsdf_pkg::t_mid     o_mid
);

    localparam int PROD_W = 48;
    localparam int SUM_W  = 52;
    localparam bit ThreeD = (DIMENSION >= 3);

    logic rdy1, rdy2, rdy3;

    logic                               r1_v;
    logic [hsdf_pkg::IDX_W-1:0]         r1_idx;
    logic signed [hsdf_pkg::WORD_W-1:0] r1_dx, r1_dy, r1_dz;
    logic signed [PROD_W-1:0]           r1_npx, r1_npy, r1_npz;
    logic signed [PROD_W-1:0]           r1_ndx, r1_ndy, r1_ndz;
    logic signed [PROD_W-1:0]           r1_off;

    logic                               r2_v;
    logic [hsdf_pkg::IDX_W-1:0]         r2_idx;
    logic signed [hsdf_pkg::WORD_W-1:0] r2_dx, r2_dy, r2_dz;
    logic signed [SUM_W-1:0]            r2_gap, r2_rate;

    logic           r3_v;
    hsdf_pkg::t_mid r3_mid;

    logic signed [hsdf_pkg::WORD_W-1:0] pz, dz;
    logic signed [PROD_W-1:0]           npx, npy, npz, ndx, ndy, ndz, off14;
    logic signed [SUM_W-1:0]            np_sum, gap, rate;
    logic signed [SUM_W:0]              diff_raw;
    logic signed [63:0]                 diff_q, gap_q;

    assign rdy3 = !r3_v || i_ready;
    assign rdy2 = !r2_v || rdy3;
    assign rdy1 = !r1_v || rdy2;
    assign i_vtx.ready = rdy1;

    assign pz = ThreeD ? i_vtx.pos_z : '0;
    assign dz = ThreeD ? i_vtx.dir_z : '0;

    assign npx   = i_cfg.normal_x * i_vtx.pos_x;
    assign npy   = i_cfg.normal_y * i_vtx.pos_y;
    assign npz   = i_cfg.normal_z * pz;
    assign ndx   = i_cfg.normal_x * i_vtx.dir_x;
    assign ndy   = i_cfg.normal_y * i_vtx.dir_y;
    assign ndz   = i_cfg.normal_z * dz;
    assign off14 = PROD_W'(i_cfg.plane_offset) <<< hsdf_pkg::FRAC_SH;

    assign np_sum = SUM_W'(r1_npx) + SUM_W'(r1_npy) + SUM_W'(r1_npz);
    assign gap    = -(np_sum + SUM_W'(r1_off));
    assign rate   = SUM_W'(r1_ndx) + SUM_W'(r1_ndy) + SUM_W'(r1_ndz);

    assign diff_raw = (SUM_W+1)'(r2_rate) - (SUM_W+1)'(r2_gap);
    assign diff_q   = hsdf_pkg::round_q14(64'(diff_raw));
    assign gap_q    = hsdf_pkg::round_q14(64'(r2_gap));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else begin
            if (rdy1) begin
                r1_v <= i_vtx.valid;
            end
            if (rdy2) begin
                r2_v <= r1_v;
            end
            if (rdy3) begin
                r3_v <= r2_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_vtx.valid) begin
            r1_idx <= i_vtx.vertex_index;
            r1_dx  <= i_vtx.dir_x;
            r1_dy  <= i_vtx.dir_y;
            r1_dz  <= dz;
            r1_npx <= npx;
            r1_npy <= npy;
            r1_npz <= npz;
            r1_ndx <= ndx;
            r1_ndy <= ndy;
            r1_ndz <= ndz;
            r1_off <= off14;
        end
        if (rdy2 && r1_v) begin
            r2_idx  <= r1_idx;
            r2_dx   <= r1_dx;
            r2_dy   <= r1_dy;
            r2_dz   <= r1_dz;
            r2_gap  <= gap;
            r2_rate <= rate;
        end
        if (rdy3 && r2_v) begin
            r3_mid.index  <= r2_idx;
            r3_mid.dir_x  <= r2_dx;
            r3_mid.dir_y  <= r2_dy;
            r3_mid.dir_z  <= r2_dz;
            r3_mid.diff   <= diff_q[hsdf_pkg::DIFF_W-1:0];
            r3_mid.active <= (r2_rate < 0) && (r2_gap > r2_rate);
            r3_mid.gap    <= hsdf_pkg::sat32(gap_q);
        end
    end

    assign o_valid = r3_v;
    assign o_mid   = r3_mid;

endmodule

`default_nettype wire

@@ rtl/core/hsdf_dir_update.sv @@
// ----------------------------------------------------------------------------
// hsdf_dir_update: direction correction and output register
// Two stages: diff times normal, then rounded subtraction and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module hsdf_dir_update (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire hsdf_pkg::t_cfg i_cfg,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire hsdf_pkg::t_mid i_mid,
    hsdf_result_if.source       o_res
);

    localparam int MUL_W = hsdf_pkg::DIFF_W + hsdf_pkg::NRM_W;

    logic rdy4, rdy5;

    logic                     r4_v;
    hsdf_pkg::t_mid           r4_mid;
    logic signed [MUL_W-1:0]  r4_px, r4_py, r4_pz;

    logic                               r5_v;
    logic [hsdf_pkg::IDX_W-1:0]         r5_idx;
    logic signed [hsdf_pkg::WORD_W-1:0] r5_nx, r5_ny, r5_nz, r5_gap;
    logic                               r5_act;

    logic signed [MUL_W-1:0] px, py, pz;
    logic signed [63:0]      ux, uy, uz;

    assign rdy5    = !r5_v || o_res.ready;
    assign rdy4    = !r4_v || rdy5;
    assign o_ready = rdy4;

    assign px = i_mid.diff * i_cfg.normal_x;
    assign py = i_mid.diff * i_cfg.normal_y;
    assign pz = i_mid.diff * i_cfg.normal_z;

    assign ux = 64'(r4_mid.dir_x) - hsdf_pkg::round_q14(64'(r4_px));
    assign uy = 64'(r4_mid.dir_y) - hsdf_pkg::round_q14(64'(r4_py));
    assign uz = 64'(r4_mid.dir_z) - hsdf_pkg::round_q14(64'(r4_pz));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
            r5_v <= 1'b0;
        end else begin
            if (rdy4) begin
                r4_v <= i_valid;
            end
            if (rdy5) begin
                r5_v <= r4_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy4 && i_valid) begin
            r4_mid <= i_mid;
            r4_px  <= px;
            r4_py  <= py;
            r4_pz  <= pz;
        end
        if (rdy5 && r4_v) begin
            r5_idx <= r4_mid.index;
            r5_act <= r4_mid.active;
            r5_gap <= r4_mid.gap;
            if (r4_mid.active) begin
                r5_nx <= hsdf_pkg::sat32(ux);
                r5_ny <= hsdf_pkg::sat32(uy);
                r5_nz <= hsdf_pkg::sat32(uz);
            end else begin
                r5_nx <= r4_mid.dir_x;
                r5_ny <= r4_mid.dir_y;
                r5_nz <= r4_mid.dir_z;
            end
        end
    end

    assign o_res.valid      = r5_v;
    assign o_res.out_index  = r5_idx;
    assign o_res.new_dir_x  = r5_nx;
    assign o_res.new_dir_y  = r5_ny;
    assign o_res.new_dir_z  = r5_nz;
    assign o_res.active     = r5_act;
    assign o_res.signed_gap = r5_gap;

endmodule

`default_nettype wire
